// File: rtl/esd_pkg.sv
package esd_pkg;

  localparam int MaxBytes   = 6;
  localparam int QueueDepth = 4;
  localparam int QptrW      = $clog2(QueueDepth);
  localparam int QcntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_X    = 8'h78;

  // One queue word: the bytes that one input character causes, and how many.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [2:0]               cnt;
  } esd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } esd_qstat_t;

  // {valid, value} of a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte} of a one-character escape.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h6E:   r = {1'b1, 8'h0A};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      8'h30:   r = {1'b1, 8'h00};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/esd_if.sv
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       seq_last;

  modport source (output valid, ch, seq_last, input ready);
  modport sink   (input valid, ch, seq_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       run_last;

  modport source (output valid, byte_out, run_last, input ready);
  modport sink   (input valid, byte_out, run_last, output ready);
endinterface

// File: rtl/esd_front.sv
module esd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        ch,
  input  logic              seq_last,
  output logic              push,
  output esd_pkg::esd_entry_t ent
);
  import esd_pkg::*;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_SKIP = 3'd1;
  localparam logic [2:0] MODE_ECHO = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_HEXX = 3'd4;

  logic [2:0]       mode_r, mode_nxt;
  logic [2:0]       dc_r, dc_nxt;
  logic [15:0]      hv_r, hv_nxt;
  logic [3:0][7:0]  raw_r, raw_nxt;

  logic [4:0]  hd;
  logic [8:0]  se;
  logic [15:0] cp;
  logic [2:0]  need;

  always_comb begin
    hd       = hex_digit(ch);
    se       = simple_escape(ch);
    cp       = {hv_r[11:0], hd[3:0]};
    need     = (mode_r == MODE_HEXU) ? 3'd4 : 3'd2;
    mode_nxt = mode_r;
    dc_nxt   = dc_r;
    hv_nxt   = hv_r;
    raw_nxt  = raw_r;
    ent      = '0;

    case (mode_r)
      MODE_IDLE: begin
        if (se[8]) begin
          ent.data[0] = se[7:0];
          ent.cnt     = 3'd1;
          mode_nxt    = MODE_SKIP;
        end else if (ch == CH_U || ch == CH_X) begin
          raw_nxt[0] = ch;
          dc_nxt     = '0;
          hv_nxt     = '0;
          mode_nxt   = (ch == CH_U) ? MODE_HEXU : MODE_HEXX;
          if (seq_last) begin
            ent.data[0] = CH_BSL;
            ent.data[1] = ch;
            ent.cnt     = 3'd2;
          end
        end else begin
          ent.data[0] = CH_BSL;
          ent.data[1] = ch;
          ent.cnt     = 3'd2;
          mode_nxt    = MODE_ECHO;
        end
      end
      MODE_ECHO: begin
        ent.data[0] = ch;
        ent.cnt     = 3'd1;
      end
      MODE_HEXU, MODE_HEXX: begin
        if (!hd[4] || (seq_last && (dc_r + 3'd1 < need))) begin
          // Fallback: backslash, the held characters, then this one.
          ent.data[0] = CH_BSL;
          for (int k = 1; k < MaxBytes; k++) begin
            if (k <= 4 && 3'(k - 1) <= dc_r) begin
              ent.data[k] = raw_r[k-1];
            end
            if (3'(k) == dc_r + 3'd2) begin
              ent.data[k] = ch;
            end
          end
          ent.cnt  = dc_r + 3'd3;
          mode_nxt = MODE_ECHO;
        end else if (dc_r + 3'd1 >= need) begin
          hv_nxt   = cp;
          mode_nxt = MODE_SKIP;
          if (mode_r == MODE_HEXX) begin
            ent.data[0] = cp[7:0];
            ent.cnt     = 3'd1;
          end else if (cp <= 16'h007F) begin
            ent.data[0] = cp[7:0];
            ent.cnt     = 3'd1;
          end else if (cp <= 16'h07FF) begin
            ent.data[0] = 8'hC0 | {3'b000, cp[10:6]};
            ent.data[1] = 8'h80 | {2'b00, cp[5:0]};
            ent.cnt     = 3'd2;
          end else begin
            ent.data[0] = 8'hE0 | {4'h0, cp[15:12]};
            ent.data[1] = 8'h80 | {2'b00, cp[11:6]};
            ent.data[2] = 8'h80 | {2'b00, cp[5:0]};
            ent.cnt     = 3'd3;
          end
        end else begin
          hv_nxt              = cp;
          dc_nxt              = dc_r + 3'd1;
          raw_nxt[dc_nxt[1:0]] = ch;
        end
      end
      default: begin
      end
    endcase

    if (seq_last) begin
      mode_nxt = MODE_IDLE;
      dc_nxt   = '0;
      hv_nxt   = '0;
    end
    push = acc && (ent.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dc_r   <= '0;
      hv_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      dc_r   <= dc_nxt;
      hv_r   <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      raw_r <= raw_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ent.cnt <= 3'(MaxBytes))
    else $error("front word longer than six bytes");
  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEXU || mode_r == MODE_HEXX) |-> dc_r <= 3'd3)
    else $error("digit count out of range");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && seq_last) |=> mode_r == MODE_IDLE && dc_r == 3'd0)
    else $error("state not cleared after final character");

endmodule

// File: rtl/esd_queue.sv
module esd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  esd_pkg::esd_entry_t wr_ent,
  input  logic                pop,
  output esd_pkg::esd_entry_t rd_ent,
  output esd_pkg::esd_qstat_t stat
);
  import esd_pkg::*;

  esd_entry_t             mem_r [QueueDepth];
  logic [QptrW-1:0]       wp_r, rp_r;
  logic [QcntW-1:0]       cnt_r;

  always_comb begin
    stat.full  = (cnt_r == QcntW'(QueueDepth));
    stat.empty = (cnt_r == '0);
    rd_ent     = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QptrW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QptrW'(1);
      end
      cnt_r <= cnt_r + QcntW'(push) - QcntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QcntW'(QueueDepth))
    else $error("queue count out of range");

endmodule

// File: rtl/esd_back.sv
module esd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  esd_pkg::esd_qstat_t stat,
  input  esd_pkg::esd_entry_t head,
  output logic                pop,
  output logic                o_valid,
  input  logic                o_ready,
  output logic [7:0]          o_byte,
  output logic                o_last
);
  import esd_pkg::*;

  esd_entry_t  cur_r;
  logic [2:0]  idx_r, idx_nxt;
  logic        busy_r, busy_nxt;
  logic        fire, fin;

  always_comb begin
    o_valid  = busy_r;
    o_byte   = cur_r.data[idx_r];
    o_last   = (idx_r + 3'd1 == cur_r.cnt);
    fire     = busy_r && o_ready;
    fin      = fire && o_last;
    pop      = !stat.empty && (!busy_r || fin);
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.cnt && cur_r.cnt != 3'd0))
    else $error("byte index beyond current word");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !o_last) |=> idx_r == $past(idx_r) + 3'd1)
    else $error("byte index did not advance");

endmodule

// File: rtl/escape_sequence_decoder.sv
// Channel   Dir  Payload              Handshake
// in_ch     in   ch[7:0], seq_last    valid/ready, taken when both high
// out_res   out  byte_out, run_last   valid/ready, taken when both high
//
// Each body character is classified in the cycle it is taken; its bytes (zero to six)
// go into a four-word queue and leave the output stage one byte per cycle while out_res
// is ready. Input runs at one character per cycle while the queue has room; a character
// holds the output until all its bytes are sent, so long fallback runs stall input.
// Reset is synchronous and active low; it empties the queue and returns to idle.
// A stalled output never blocks input until the queue is full.
module escape_sequence_decoder (
  input logic      clk,
  input logic      rst_n,
  esd_in_if.sink   in_ch,
  esd_out_if.source out_res
);
  import esd_pkg::*;

  logic       acc, push, pop;
  esd_entry_t wr_ent, head;
  esd_qstat_t stat;

  assign in_ch.ready = !stat.full;
  assign acc         = in_ch.valid && in_ch.ready;

  esd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .ch       (in_ch.ch),
    .seq_last (in_ch.seq_last),
    .push     (push),
    .ent      (wr_ent)
  );

  esd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_ent (wr_ent),
    .pop    (pop),
    .rd_ent (head),
    .stat   (stat)
  );

  esd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .head    (head),
    .pop     (pop),
    .o_valid (out_res.valid),
    .o_ready (out_res.ready),
    .o_byte  (out_res.byte_out),
    .o_last  (out_res.run_last)
  );

endmodule

// File: verif/esd_checker.sv
`timescale 1ns / 100ps

module esd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_seq_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  output int         fail_count,
  output int         pending
);
  import esd_pkg::*;

  typedef enum logic [2:0] {DecIdle, DecSkip, DecEcho, DecHexU, DecHexX} dec_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  dec_mode_t   mode;
  logic [2:0]  digits_held;
  logic [15:0] code_acc;
  logic [7:0]  held_chars [4];
  logic [7:0]  burst [$];
  out_word_t   expected_words [$];

  function automatic void add_byte(input logic [7:0] b);
    burst.insert(burst.size(), b);
  endfunction

  function automatic int hex_value_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic int escape_byte(input logic [7:0] c);
    case (c)
      "n":     return 'h0A;
      "t":     return 'h09;
      "r":     return 'h0D;
      "0":     return 'h00;
      "\\":    return 'h5C;
      "\"":    return 'h22;
      "'":     return 'h27;
      "a":     return 'h07;
      "b":     return 'h08;
      "f":     return 'h0C;
      "v":     return 'h0B;
      default: return -1;
    endcase
  endfunction

  // Backslash, the selector and any digits held so far, then the offending word.
  task automatic emit_fallback(input logic [7:0] c);
    add_byte(CH_BSL);
    for (int i = 0; i <= digits_held && i < 4; i++) begin
      add_byte(held_chars[i]);
    end
    add_byte(c);
    mode = DecEcho;
  endtask

  task automatic emit_utf8(input logic [15:0] cp);
    if (cp <= 16'h007F) begin
      add_byte(cp[7:0]);
    end else if (cp <= 16'h07FF) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic decode_word(input logic [7:0] c, input logic last);
    int        esc;
    int        dig;
    int        need;
    out_word_t w;
    burst.delete();
    case (mode)
      DecIdle: begin
        esc = escape_byte(c);
        if (esc >= 0) begin
          add_byte(esc[7:0]);
          mode = DecSkip;
        end else if (c == CH_U || c == CH_X) begin
          held_chars[0] = c;
          digits_held = '0;
          code_acc = '0;
          mode = (c == CH_U) ? DecHexU : DecHexX;
          if (last) begin
            add_byte(CH_BSL);
            add_byte(c);
          end
        end else begin
          add_byte(CH_BSL);
          add_byte(c);
          mode = DecEcho;
        end
      end
      DecEcho: add_byte(c);
      DecHexU, DecHexX: begin
        need = (mode == DecHexU) ? 4 : 2;
        dig = hex_value_of(c);
        if (dig < 0) begin
          emit_fallback(c);
        end else if (digits_held + 1 >= need) begin
          code_acc = {code_acc[11:0], dig[3:0]};
          if (mode == DecHexU) begin
            emit_utf8(code_acc);
          end else begin
            add_byte(code_acc[7:0]);
          end
          mode = DecSkip;
        end else if (last) begin
          emit_fallback(c);
        end else begin
          code_acc = {code_acc[11:0], dig[3:0]};
          digits_held = digits_held + 3'd1;
          held_chars[digits_held[1:0]] = c;
        end
      end
      default: ;
    endcase
    if (last) begin
      mode = DecIdle;
      digits_held = '0;
      code_acc = '0;
    end
    for (int i = 0; i < burst.size(); i++) begin
      w.data = burst[i];
      w.last = (i == burst.size() - 1);
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (!rst_n) begin
      mode = DecIdle;
      digits_held = '0;
      code_acc = '0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(in_ch, in_seq_last);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected output word: byte %h last %b", out_byte, out_run_last);
          end
        end else begin
          w = expected_words.pop_front();
          if (out_byte !== w.data || out_run_last !== w.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch: expected byte %h last %b, got byte %h last %b",
                       w.data, w.last, out_byte, out_run_last);
            end
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import esd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int ItemTarget  = 230;

  logic clk;
  logic rst_n;
  logic sender_idles;
  logic receiver_idles;
  logic hold_output;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   items_sent;
  logic [7:0] body_chars [$];

  esd_in_if  in_ch_if ();
  esd_out_if out_res_if ();

  escape_sequence_decoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch_if),
    .out_res (out_res_if)
  );

  esd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch_if.valid),
    .in_ready     (in_ch_if.ready),
    .in_ch        (in_ch_if.ch),
    .in_seq_last  (in_ch_if.seq_last),
    .out_valid    (out_res_if.valid),
    .out_ready    (out_res_if.ready),
    .out_byte     (out_res_if.byte_out),
    .out_run_last (out_res_if.run_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int w;
    out_res_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_output = 1'b0;
      end
      w = receiver_idles ? $urandom_range(0, 4) : 0;
      if (w > 0) begin
        out_res_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_res_if.ready <= 1'b1;
      do @(posedge clk); while (!out_res_if.valid);
    end
  end

  function automatic void add_char(input logic [7:0] c);
    body_chars.insert(body_chars.size(), c);
  endfunction

  task automatic send_word(input logic [7:0] c, input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch_if.valid    <= 1'b1;
    in_ch_if.ch       <= c;
    in_ch_if.seq_last <= last;
    do @(posedge clk); while (!in_ch_if.ready);
  endtask

  task automatic send_body();
    int n;
    n = body_chars.size();
    for (int i = 0; i < n; i++) begin
      send_word(body_chars[i], i == n - 1);
    end
    items_sent += n;
    body_chars.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
    send_body();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0") + v;
    return 8'(($urandom_range(0, 1) ? 8'("a") : 8'("A")) + v - 10);
  endfunction

  task automatic push_hex(input int value, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) begin
      add_char(hex_char(4'(value >> (4 * i))));
    end
  endtask

  task automatic push_random(input int n);
    repeat (n) add_char(8'($urandom_range(0, 255)));
  endtask

  // A byte that is never a hex digit.
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h00, 8'h2F));
      1:       return 8'($urandom_range(8'h3A, 8'h40));
      2:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  task automatic make_body();
    string simple_set;
    string unknown_set;
    int    kind;
    int    need;
    int    n;
    logic [7:0] sel;
    simple_set  = "ntr0\\\"'abfv";
    unknown_set = "cdeghijkmopqswyzGXU1Z9#";
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, 1) ? CH_U : CH_X;
    need = (sel == CH_U) ? 4 : 2;
    if (kind < 20) begin
      add_char(simple_set[$urandom_range(0, simple_set.len() - 1)]);
      push_random($urandom_range(0, 2));
    end else if (kind < 45) begin
      add_char(CH_U);
      case ($urandom_range(0, 2))
        0:       push_hex($urandom_range(16'h0000, 16'h007F), 4);
        1:       push_hex($urandom_range(16'h0080, 16'h07FF), 4);
        default: push_hex($urandom_range(16'h0800, 16'hFFFF), 4);
      endcase
      push_random($urandom_range(0, 1));
    end else if (kind < 60) begin
      add_char(CH_X);
      push_hex($urandom_range(0, 255), 2);
      push_random($urandom_range(0, 1));
    end else if (kind < 72) begin
      add_char(sel);
      push_hex($urandom, $urandom_range(0, need - 1));
      add_char(non_hex_char());
      push_random($urandom_range(0, 2));
    end else if (kind < 82) begin
      // Body ends before the digits are complete.
      add_char(sel);
      push_hex($urandom, $urandom_range(0, need - 1));
    end else if (kind < 92) begin
      if ($urandom_range(0, 1)) begin
        add_char(8'($urandom_range(8'h80, 8'hFF)));
      end else begin
        add_char(unknown_set[$urandom_range(0, unknown_set.len() - 1)]);
      end
      push_random($urandom_range(0, 3));
    end else begin
      n = $urandom_range(1, 4);
      push_random(n);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch_if.valid    = 1'b0;
    in_ch_if.ch       = '0;
    in_ch_if.seq_last = 1'b0;
    sender_idles      = 1'b1;
    receiver_idles    = 1'b1;
    hold_output       = 1'b0;
    items_sent        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("nq");
    send_text("uFfFf");
    send_text("x00z");
    send_text("u123Gk");
    add_char(8'hFF);
    add_char(8'h00);
    send_body();
    send_text("x");
    send_text("x4");

    while (items_sent < 100) begin
      make_body();
      send_body();
    end

    // Let everything drain before the next stretch.
    in_ch_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Back-to-back words against a stalled output so the block fills up.
    hold_output    = 1'b1;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    while (items_sent < 150) begin
      make_body();
      send_body();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    while (items_sent < ItemTarget) begin
      make_body();
      send_body();
    end

    in_ch_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/esd_pkg.sv
rtl/esd_if.sv
rtl/esd_front.sv
rtl/esd_queue.sv
rtl/esd_back.sv
rtl/escape_sequence_decoder.sv
verif/esd_checker.sv
verif/testbench.sv
